### src/esmt_pkg.sv
// Shared types, constants and scale table for the encoder speed estimator.
// No dependencies; every other file in src except esmt_ram imports this package.
`default_nettype none

package esmt_pkg;

	// Moving-average ring
	localparam int AVG_DEPTH = 8;
	localparam int RING_AW   = $clog2(AVG_DEPTH);
	localparam int SUM_W     = 32 + RING_AW;
	localparam bit AVG_POW2  = ((AVG_DEPTH & (AVG_DEPTH - 1)) == 0);

	// Datapath widths
	localparam int NUM_W      = 64;          // dividend: pulses * unit scale
	localparam int DEN_W      = 42;          // counts_per_rev * window_us
	localparam int DIV_W      = DEN_W + 16;  // divisor, with rad/s shift
	localparam int DSH_W      = DIV_W + 31;  // divisor aligned to quotient msb
	localparam int SCALE_W    = 47;
	localparam int SCALE_LO_W = 24;
	localparam int SCALE_HI_W = SCALE_W - SCALE_LO_W;
	localparam int DIV_ITER   = 32;
	localparam int ITER_W     = 5;

	// 60 s * 10^6 us: rpm above limit <=> RPM_US > limit * period
	localparam logic [47:0] RPM_US = 48'd60000000;

	// Configuration port
	localparam int CFG_AW = 5;
	localparam logic [2:0] REG_UNIT   = 3'd0;
	localparam logic [2:0] REG_WINDOW = 3'd1;
	localparam logic [2:0] REG_CPR    = 3'd2;
	localparam logic [2:0] REG_LOW    = 3'd3;
	localparam logic [2:0] REG_FAST   = 3'd4;

	localparam logic [1:0]  RST_UNIT   = 2'd0;
	localparam logic [25:0] RST_WINDOW = 26'd1000000;
	localparam logic [15:0] RST_CPR    = 16'd960;
	localparam logic [15:0] RST_LOW    = 16'd10;
	localparam logic [15:0] RST_FAST   = 16'd35;

	// Output unit codes
	localparam logic [1:0] UNIT_RPM  = 2'd0;
	localparam logic [1:0] UNIT_RPS  = 2'd1;
	localparam logic [1:0] UNIT_HZ   = 2'd2;
	localparam logic [1:0] UNIT_RADS = 2'd3;

	typedef struct packed {
		logic [1:0]  unit_sel;
		logic [25:0] window_us;
		logic [15:0] counts_per_rev;
		logic [15:0] low_pulse_limit;
		logic [15:0] fast_rpm_limit;
	} cfg_t;

	typedef struct packed {
		logic load;      // latch input word, start products
		logic mode;      // decide mode, read old ring entry
		logic mul_lo;    // low partial product, select divisor
		logic mul_hi;    // high partial product, form dividend
		logic div_set;   // load divider with speed operands
		logic avg_set;   // load divider with ring sum
		logic div_step;  // one quotient bit
		logic ring;      // store speed, update running sum
		logic emit;      // hand result to output register
	} cmd_t;

	typedef struct packed {
		logic skip;      // speed is saturated or zero, no divide needed
	} stat_t;

	typedef struct packed {
		logic [31:0] speed_avg;
		logic        count_mode;
		logic        start_period_timer;
		logic        stop_period_timer;
	} res_t;

	// 256 * 10^6 times the unit factor (60 for rpm, 2*pi in Q16 for rad/s)
	function automatic logic [SCALE_W-1:0] unit_scale(input logic [1:0] u);
		logic [SCALE_W-1:0] k;
		case (u)
			UNIT_RPM:  k = 47'd15360000000;
			UNIT_RPS:  k = 47'd256000000;
			UNIT_HZ:   k = 47'd256000000;
			UNIT_RADS: k = 47'd105414400000000;
			default:   k = 47'd256000000;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

### src/esmt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module esmt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### src/esmt_ctrl.sv
// Sequencer of the speed estimator: walks one word through mode decision,
// products, division, ring update and averaging. Depends on esmt_pkg.
`default_nettype none

module esmt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_free,
	input  esmt_pkg::stat_t stat,
	output logic            in_ready,
	output esmt_pkg::cmd_t  cmd
);

	import esmt_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_MODE    = 10'b00_0000_0010,
		S_MUL_LO  = 10'b00_0000_0100,
		S_MUL_HI  = 10'b00_0000_1000,
		S_DIV_SET = 10'b00_0001_0000,
		S_DIV_RUN = 10'b00_0010_0000,
		S_RING    = 10'b00_0100_0000,
		S_AVG_SET = 10'b00_1000_0000,
		S_AVG_RUN = 10'b01_0000_0000,
		S_DONE    = 10'b10_0000_0000
	} state_t;

	state_t            state_q, state_d;
	logic [ITER_W-1:0] cnt_q;
	logic              accept;
	logic              last_iter;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign last_iter = (cnt_q == ITER_W'(DIV_ITER - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (accept) state_d = S_MODE;
			S_MODE:    state_d = S_MUL_LO;
			S_MUL_LO:  state_d = S_MUL_HI;
			S_MUL_HI:  state_d = S_DIV_SET;
			S_DIV_SET: state_d = stat.skip ? S_RING : S_DIV_RUN;
			S_DIV_RUN: if (last_iter) state_d = S_RING;
			S_RING:    state_d = AVG_POW2 ? S_DONE : S_AVG_SET;
			S_AVG_SET: state_d = S_AVG_RUN;
			S_AVG_RUN: if (last_iter) state_d = S_DONE;
			S_DONE:    if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd          = '0;
		cmd.load     = accept;
		cmd.mode     = (state_q == S_MODE);
		cmd.mul_lo   = (state_q == S_MUL_LO);
		cmd.mul_hi   = (state_q == S_MUL_HI);
		cmd.div_set  = (state_q == S_DIV_SET);
		cmd.avg_set  = (state_q == S_AVG_SET);
		cmd.div_step = (state_q == S_DIV_RUN) || (state_q == S_AVG_RUN);
		cmd.ring     = (state_q == S_RING);
		cmd.emit     = (state_q == S_DONE) && out_free;
	end

	// State and iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_set || cmd.avg_set) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + ITER_W'(1);
			end
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input taken while a word is in flight");

	a_cnt_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV_SET || state_q == S_AVG_SET) |=> cnt_q == '0)
		else $error("divide counter not cleared at start");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (out_free && !in_ready))
		else $error("result emitted into a full output register");

endmodule

`default_nettype wire

### src/esmt_dp.sv
// Datapath of the speed estimator: mode logic, products, shared restoring
// divider, ring store with running sum. Depends on esmt_pkg and esmt_ram.
`default_nettype none

module esmt_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  esmt_pkg::cfg_t  cfg,
	input  esmt_pkg::cmd_t  cmd,
	input  logic [15:0]     pulse_count,
	input  logic [31:0]     rev_period_us,
	output esmt_pkg::stat_t stat,
	output esmt_pkg::res_t  res
);

	import esmt_pkg::*;

	// Input word and first products
	logic [15:0]        pulses_q;
	logic [31:0]        period_q;
	logic [47:0]        fast_prod_q;
	logic [DEN_W-1:0]   den_cd_q;
	// Mode state
	logic               mode_q, first_q, start_q, stop_q;
	// Dividend and divisor
	logic [39:0]        prod_lo_q;
	logic [NUM_W-1:0]   num_q;
	logic [DIV_W-1:0]   d_q;
	logic               sat_q, zero_q;
	// Divider
	logic [NUM_W-1:0]   rem_q;
	logic [DSH_W-1:0]   dsh_q;
	logic [31:0]        quot_q;
	// Ring
	logic [RING_AW-1:0] ptr_q;
	logic [AVG_DEPTH-1:0] valid_q;
	logic [SUM_W-1:0]   sum_q;
	logic [31:0]        rdata;

	logic [15:0]           cpr1, low_unused_w;
	logic [25:0]           win1;
	logic                  fast_w, sat_w, zero_w, ge_w;
	logic [15:0]           sel_in;
	logic [SCALE_W-1:0]    scale;
	logic [DEN_W-1:0]      den_sel;
	logic [38:0]           prod_hi_w;
	logic [31:0]           speed_w, old_w, avg_w;

	// Treat a zero divisor register as one
	assign cpr1 = (cfg.counts_per_rev == '0) ? 16'd1 : cfg.counts_per_rev;
	assign win1 = (cfg.window_us == '0) ? 26'd1 : cfg.window_us;
	assign low_unused_w = cfg.low_pulse_limit;

	// Zero period counts as fast
	assign fast_w = (period_q == '0) || (RPM_US > fast_prod_q);

	assign sel_in    = mode_q ? pulses_q : 16'd1;
	assign scale     = unit_scale(cfg.unit_sel);
	assign den_sel   = mode_q ? den_cd_q : DEN_W'(period_q);
	assign prod_hi_w = 39'(sel_in) * 39'(scale[SCALE_W-1:SCALE_LO_W]);

	// Quotient would not fit 32 bits
	assign sat_w  = (DIV_W'(num_q[NUM_W-1:32]) >= d_q);
	assign zero_w = !mode_q && (period_q == '0);
	assign stat.skip = sat_w || zero_w;

	assign ge_w    = ({{(DSH_W - NUM_W){1'b0}}, rem_q} >= dsh_q);
	assign speed_w = zero_q ? 32'd0 : (sat_q ? 32'hFFFF_FFFF : quot_q);
	assign old_w   = valid_q[ptr_q] ? rdata : 32'd0;
	assign avg_w   = AVG_POW2 ? sum_q[RING_AW +: 32] : quot_q;

	// Latch input word and start products
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pulses_q    <= pulse_count;
			period_q    <= rev_period_us;
			fast_prod_q <= 48'(cfg.fast_rpm_limit) * 48'(rev_period_us);
			den_cd_q    <= DEN_W'(cpr1) * DEN_W'(win1);
		end
	end

	// Mode switch, not on the first word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b1;
			first_q <= 1'b1;
			start_q <= 1'b0;
			stop_q  <= 1'b0;
		end else if (cmd.mode) begin
			first_q <= 1'b0;
			start_q <= !first_q && mode_q && (pulses_q < low_unused_w);
			stop_q  <= !first_q && !mode_q && fast_w;
			if (!first_q) begin
				if (!mode_q && fast_w) begin
					mode_q <= 1'b1;
				end else if (mode_q && (pulses_q < low_unused_w)) begin
					mode_q <= 1'b0;
				end
			end
		end
	end

	// Dividend in two partial products, divisor by mode and unit
	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			prod_lo_q <= 40'(sel_in) * 40'(scale[SCALE_LO_W-1:0]);
			d_q <= (cfg.unit_sel == UNIT_RADS) ? {den_sel, 16'b0} : DIV_W'(den_sel);
		end
		if (cmd.mul_hi) begin
			num_q <= (NUM_W'(prod_hi_w) << SCALE_LO_W) + NUM_W'(prod_lo_q);
		end
		if (cmd.div_set) begin
			sat_q  <= sat_w;
			zero_q <= zero_w;
		end
	end

	// Shared restoring divider, one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.div_set) begin
			rem_q  <= num_q;
			dsh_q  <= {d_q, 31'b0};
			quot_q <= '0;
		end else if (cmd.avg_set) begin
			rem_q  <= NUM_W'(sum_q);
			dsh_q  <= DSH_W'(AVG_DEPTH) << 31;
			quot_q <= '0;
		end else if (cmd.div_step) begin
			if (ge_w) begin
				rem_q <= rem_q - dsh_q[NUM_W-1:0];
			end
			quot_q <= {quot_q[30:0], ge_w};
			dsh_q  <= dsh_q >> 1;
		end
	end

	// Ring store; old entry read during mode decision
	esmt_ram #(
		.WIDTH(32),
		.DEPTH(AVG_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (cmd.ring),
		.waddr (ptr_q),
		.wdata (speed_w),
		.re    (cmd.mode),
		.raddr (ptr_q),
		.rdata (rdata)
	);

	// Running sum, pointer and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			valid_q <= '0;
			sum_q   <= '0;
		end else if (cmd.ring) begin
			sum_q          <= sum_q - SUM_W'(old_w) + SUM_W'(speed_w);
			valid_q[ptr_q] <= 1'b1;
			ptr_q <= (ptr_q == RING_AW'(AVG_DEPTH - 1)) ? '0 : ptr_q + RING_AW'(1);
		end
	end

	assign res.speed_avg          = avg_w;
	assign res.count_mode         = mode_q;
	assign res.start_period_timer = start_q;
	assign res.stop_period_timer  = stop_q;

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(start_q && stop_q))
		else $error("both timer flags set");

	a_flags_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(!start_q || !mode_q) && (!stop_q || mode_q))
		else $error("timer flag disagrees with mode");

	a_first_once: assert property (@(posedge clk) disable iff (!arst_n)
		!first_q |=> !first_q)
		else $error("first-word mark came back");

endmodule

`default_nettype wire

### src/encoder_speed_mt_estimator.sv
// Top level of the encoder speed estimator (M/T method, moving average):
// APB register file, output register, sequencer and datapath.
// Depends on esmt_pkg, esmt_ctrl, esmt_dp (and esmt_ram through esmt_dp).
//
//   channel   handshake              word
//   -------   --------------------   -------------------------------------------
//   in        in_valid / in_ready    pulse_count, rev_period_us
//   out       out_valid / out_ready  speed_avg, count_mode, start/stop_period_timer
//   cfg       APB psel/penable       paddr, pwdata, prdata (pready tied high)
//
// A word passes from acceptance through mode decision, products and the 32-step
// restoring divider to the output register; a ring depth that is not a power of two
// adds a second 32-step divide for the average. The next word is accepted the cycle
// after the result is registered. Zero or saturated speeds bypass the speed divide.
// Reset sets count mode and clears ring valid bits, running sum and pointer at once.
// A stalled output holds the result; the block then holds one more word.
`default_nettype none

module encoder_speed_mt_estimator (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [15:0]                  pulse_count,
	input  logic [31:0]                  rev_period_us,
	// Output channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [31:0]                  speed_avg,
	output logic                         count_mode,
	output logic                         start_period_timer,
	output logic                         stop_period_timer,
	// Configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [esmt_pkg::CFG_AW-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	import esmt_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;
	res_t  res, res_q;
	logic  out_valid_q;
	logic  out_free;
	logic  wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[CFG_AW-1:2];

	// Register writes, masked to width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit_sel        <= RST_UNIT;
			cfg_q.window_us       <= RST_WINDOW;
			cfg_q.counts_per_rev  <= RST_CPR;
			cfg_q.low_pulse_limit <= RST_LOW;
			cfg_q.fast_rpm_limit  <= RST_FAST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_UNIT:   cfg_q.unit_sel        <= pwdata[1:0];
				REG_WINDOW: cfg_q.window_us       <= pwdata[25:0];
				REG_CPR:    cfg_q.counts_per_rev  <= pwdata[15:0];
				REG_LOW:    cfg_q.low_pulse_limit <= pwdata[15:0];
				REG_FAST:   cfg_q.fast_rpm_limit  <= pwdata[15:0];
				default:    ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (reg_idx)
			REG_UNIT:   prdata = {30'b0, cfg_q.unit_sel};
			REG_WINDOW: prdata = {6'b0, cfg_q.window_us};
			REG_CPR:    prdata = {16'b0, cfg_q.counts_per_rev};
			REG_LOW:    prdata = {16'b0, cfg_q.low_pulse_limit};
			REG_FAST:   prdata = {16'b0, cfg_q.fast_rpm_limit};
			default:    prdata = '0;
		endcase
	end

	esmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	esmt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.pulse_count   (pulse_count),
		.rev_period_us (rev_period_us),
		.stat          (stat),
		.res           (res)
	);

	// Output register: hold the word until taken
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q <= res;
		end
	end

	assign out_valid          = out_valid_q;
	assign speed_avg          = res_q.speed_avg;
	assign count_mode         = res_q.count_mode;
	assign start_period_timer = res_q.start_period_timer;
	assign stop_period_timer  = res_q.stop_period_timer;

endmodule

`default_nettype wire
